// ----- src/shtp_pkg.sv -----
// ----------------------------------------------------------------------------
// shtp_pkg
// Shared types, constants and elaboration helpers for the symbol table probe.
// ----------------------------------------------------------------------------
package shtp_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int NAME_CHARS_DEF    = 8;
	localparam int QUEUE_DEPTH       = 2;
	localparam int SYM_W             = 64;
	localparam int SLOT_IDX_W        = 10;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [1:0] {
		F_IDLE,
		F_REDUCE,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_CHECK
	} back_state_t;

	// number of shift-and-subtract steps for a remainder by modulus, given the
	// largest value that can arrive
	function automatic int reduce_steps(int modulus, int sum_max);
		int n;
		n = 0;
		for (int i = 0; i < 24; i++) begin
			if ((longint'(modulus) << i) <= longint'(sum_max)) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

endpackage

// ----- src/shtp_fifo.sv -----
// ----------------------------------------------------------------------------
// shtp_fifo
// Small request queue between the hashing front end and the probe engine.
// ----------------------------------------------------------------------------
module shtp_fifo import shtp_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] data_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/shtp_front.sv -----
// ----------------------------------------------------------------------------
// shtp_front
// Takes requests, trims the name and reduces its byte sum to the home slot.
// ----------------------------------------------------------------------------
module shtp_front import shtp_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int NAME_CHARS    = NAME_CHARS_DEF,
	localparam int SLOT_W       = $clog2(TABLE_ENTRIES),
	localparam int NAME_W       = 8 * NAME_CHARS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              operation,
	input  logic [SYM_W-1:0]  symbol_name,
	input  logic              clearing,
	output logic              q_push,
	input  logic              q_full,
	output logic [NAME_W+SLOT_W:0] q_data
);

	localparam int SUM_MAX = 255 * NAME_CHARS;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int MODULUS = TABLE_ENTRIES - 2;
	localparam int NSTEP   = reduce_steps(MODULUS, SUM_MAX);
	localparam int SH_W    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

	front_state_t      state_q;
	front_state_t      state_d;
	logic              op_q;
	logic [NAME_W-1:0] name_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SH_W-1:0]   shift_q;
	logic [NAME_W-1:0] kept;
	logic [SUM_W-1:0]  total;
	logic [31:0]       sub_w;
	logic              accept;

	// keep bytes up to the first zero byte
	always_comb begin
		logic alive;
		logic [7:0] b;
		kept  = '0;
		total = '0;
		alive = 1'b1;
		for (int k = 0; k < NAME_CHARS; k++) begin
			b = symbol_name[8*k +: 8];
			if (alive && b != 8'd0) begin
				kept[8*k +: 8] = b;
				total = total + SUM_W'(b);
			end else begin
				alive = 1'b0;
			end
		end
	end

	assign sub_w = 32'(MODULUS) << shift_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (NSTEP == 0) ? F_PUSH : F_REDUCE;
				end
			end
			F_REDUCE: begin
				if (shift_q == '0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		full   = (state_q != F_IDLE) || clearing;
		accept = push && !full;
		q_push = (state_q == F_PUSH) && !q_full;
		q_data = {op_q, name_q, SLOT_W'(rem_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			name_q  <= kept;
			rem_q   <= total;
			shift_q <= SH_W'((NSTEP > 0) ? NSTEP - 1 : 0);
		end else if (state_q == F_REDUCE) begin
			if (32'(rem_q) >= sub_w) begin
				rem_q <= SUM_W'(32'(rem_q) - sub_w);
			end
			shift_q <= shift_q - 1'b1;
		end
	end

endmodule

// ----- src/shtp_back.sv -----
// ----------------------------------------------------------------------------
// shtp_back
// Probe engine: walks the table from the home slot, inserts, drives results.
// ----------------------------------------------------------------------------
module shtp_back import shtp_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int NAME_CHARS    = NAME_CHARS_DEF,
	localparam int SLOT_W       = $clog2(TABLE_ENTRIES),
	localparam int NAME_W       = 8 * NAME_CHARS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  logic [NAME_W+SLOT_W:0] q_data,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  empty,
	input  logic                  pop,
	output logic                  found,
	output logic [SLOT_IDX_W-1:0] slot_index,
	output logic                  status
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] probes_q;
	logic              op_q;
	logic [NAME_W-1:0] name_q;

	// entry layout: used mark on top, stored name below
	logic [NAME_W:0]   entry_mem [TABLE_ENTRIES];
	logic [NAME_W:0]   rd_q;

	logic              out_valid_q;
	logic              found_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic              status_q;

	logic              q_op;
	logic [NAME_W-1:0] q_name;
	logic [SLOT_W-1:0] q_home;
	logic              free_hit;
	logic              name_hit;
	logic              exhausted;
	logic              done;
	logic              commit;
	logic              out_xfer;
	logic [SLOT_W-1:0] slot_next;
	logic [SLOT_W-1:0] rd_addr;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [NAME_W:0]   wr_data;

	assign {q_op, q_name, q_home} = q_data;

	assign free_hit  = !rd_q[NAME_W];
	assign name_hit  = rd_q[NAME_W] && (rd_q[NAME_W-1:0] == name_q);
	assign exhausted = (probes_q == SLOT_W'(TABLE_ENTRIES - 1));
	assign done      = (state_q == B_CHECK) && (free_hit || name_hit || exhausted);
	assign out_xfer  = pop && out_valid_q;
	assign commit    = done && (!out_valid_q || pop);
	assign slot_next = (slot_q == SLOT_W'(TABLE_ENTRIES - 1)) ? '0 : slot_q + 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == SLOT_W'(TABLE_ENTRIES - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					state_d = B_CHECK;
				end
			end
			B_CHECK: begin
				if (commit) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == B_IDLE) && !q_empty;
		clearing = (state_q == B_CLEAR);
		// hold the current slot while a finished result waits for the output
		if (state_q == B_IDLE) begin
			rd_addr = q_home;
		end else if (state_q == B_CHECK && !done) begin
			rd_addr = slot_next;
		end else begin
			rd_addr = slot_q;
		end
		wr_en   = clearing || (commit && free_hit && (op_q == OP_INSERT));
		wr_addr = clearing ? clr_q : slot_q;
		wr_data = clearing ? '0 : {1'b1, name_q};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		rd_q <= entry_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			slot_q   <= q_home;
			probes_q <= '0;
			op_q     <= q_op;
			name_q   <= q_name;
		end else if (state_q == B_CHECK && !done) begin
			slot_q   <= slot_next;
			probes_q <= probes_q + 1'b1;
		end
		if (commit) begin
			found_q    <= !free_hit && name_hit;
			status_q   <= !free_hit && !name_hit;
			slot_out_q <= (free_hit || name_hit) ? slot_q : '0;
		end
	end

	assign empty      = !out_valid_q;
	assign found      = found_q;
	assign status     = status_q;
	assign slot_index = SLOT_IDX_W'(slot_out_q);

endmodule

// ----- src/symbol_hash_table_probe.sv -----
// ----------------------------------------------------------------------------
// symbol_hash_table_probe
// Open-addressing symbol table with linear probing, queue-style ports.
// ----------------------------------------------------------------------------
// After reset the table is cleared one entry per cycle, and full stays high
// during that pass. The front end latches a request, reduces its byte sum
// in remainder steps (one step at the default size, more for small tables)
// and queues it, waiting while the queue is full. The probe engine takes a
// request off the queue and probes the table from the home slot on through
// the single read port of the table memory until it finds a free slot or the
// name or has walked the whole table. Results wait in an output register, so
// the engine keeps working until it has a second result to hand over.
module symbol_hash_table_probe import shtp_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int NAME_CHARS    = NAME_CHARS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  operation,
	input  logic [SYM_W-1:0]      symbol_name,
	output logic                  empty,
	input  logic                  pop,
	output logic                  found,
	output logic [SLOT_IDX_W-1:0] slot_index,
	output logic                  status
);

	localparam int SLOT_W = $clog2(TABLE_ENTRIES);
	localparam int NAME_W = 8 * NAME_CHARS;
	localparam int REQ_W  = 1 + NAME_W + SLOT_W;

	logic             clearing;
	logic             fq_push;
	logic             fq_full;
	logic [REQ_W-1:0] fq_wdata;
	logic             fq_pop;
	logic             fq_empty;
	logic [REQ_W-1:0] fq_rdata;

	shtp_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.NAME_CHARS    (NAME_CHARS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.symbol_name (symbol_name),
		.clearing    (clearing),
		.q_push      (fq_push),
		.q_full      (fq_full),
		.q_data      (fq_wdata)
	);

	shtp_fifo #(
		.DATA_W (REQ_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_wdata),
		.rd_en   (fq_pop),
		.rd_data (fq_rdata),
		.full    (fq_full),
		.empty   (fq_empty)
	);

	shtp_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.NAME_CHARS    (NAME_CHARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (fq_empty),
		.q_data     (fq_rdata),
		.q_pop      (fq_pop),
		.clearing   (clearing),
		.empty      (empty),
		.pop        (pop),
		.found      (found),
		.slot_index (slot_index),
		.status     (status)
	);

endmodule

// ----- verif/symbol_hash_table_probe_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// symbol_hash_table_probe_tb
// Self-checking bench for the symbol table probe engine. Requests are fed in
// bursts through the push/full side and results drained through the pop/empty
// side with a varying stall pattern. A shadow table predicts every result.
// Stimulus runs directed wrap and collision cases, then mixed random traffic.
// ----------------------------------------------------------------------------
module symbol_hash_table_probe_tb;
	import shtp_pkg::*;

	localparam int  ENTRIES     = TABLE_ENTRIES_DEF;
	localparam int  HOME_MOD    = TABLE_ENTRIES_DEF - 2;
	localparam int  RANDOM_REQS = 430;
	localparam int  HOLD_CYCLES = 600;
	localparam int  CYCLE_LIMIT = 1000000;
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_OVERFLOW = 1'b1;

	typedef struct {
		logic             op;
		logic [SYM_W-1:0] name;
	} symbol_req_t;

	typedef struct {
		logic                  found;
		logic [SLOT_IDX_W-1:0] slot;
		logic                  status;
	} probe_result_t;

	typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  push        = 1'b0;
	logic                  operation   = OP_LOOKUP;
	logic [SYM_W-1:0]      symbol_name = '0;
	logic                  pop         = 1'b0;
	logic                  full;
	logic                  empty;
	logic                  found;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic                  status;

	// shadow table
	logic [SYM_W-1:0] shadow_name [ENTRIES];
	bit               shadow_used [ENTRIES];

	symbol_req_t   request_q[$];
	probe_result_t probe_results_q[$];
	bit            known_names[logic [SYM_W-1:0]];
	logic [SYM_W-1:0] name_pool[$];

	int n_queued   = 0;
	int n_accepted = 0;
	int n_errors   = 0;
	int n_found    = 0;
	int n_absent   = 0;
	int n_overflow = 0;
	int n_cycles   = 0;

	symbol_hash_table_probe i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.symbol_name (symbol_name),
		.empty       (empty),
		.pop         (pop),
		.found       (found),
		.slot_index  (slot_index),
		.status      (status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// keep bytes up to the first zero byte
	function automatic logic [SYM_W-1:0] strip_name(input logic [SYM_W-1:0] raw);
		logic [SYM_W-1:0] kept;
		int k;
		kept = '0;
		for (k = 0; k < NAME_CHARS_DEF; k++) begin
			if (raw[8*k +: 8] == 8'd0)
				break;
			kept[8*k +: 8] = raw[8*k +: 8];
		end
		return kept;
	endfunction

	function automatic int byte_sum(input logic [SYM_W-1:0] kept);
		int k;
		int total;
		total = 0;
		for (k = 0; k < 8; k++)
			total += kept[8*k +: 8];
		return total;
	endfunction

	function automatic int name_len(input logic [SYM_W-1:0] kept);
		int k;
		for (k = 0; k < 8; k++)
			if (kept[8*k +: 8] == 8'd0)
				return k;
		return 8;
	endfunction

	// walk the shadow table the way the engine does, updating it on insert
	function automatic probe_result_t probe_symbol(input logic op, input logic [SYM_W-1:0] raw);
		probe_result_t res;
		logic [SYM_W-1:0] kept;
		int slot;
		int n;
		kept = strip_name(raw);
		slot = byte_sum(kept) % HOME_MOD;
		for (n = 0; n < ENTRIES; n++) begin
			if (!shadow_used[slot]) begin
				if (op == OP_INSERT) begin
					shadow_name[slot] = kept;
					shadow_used[slot] = 1'b1;
				end
				res.found  = 1'b0;
				res.slot   = SLOT_IDX_W'(slot);
				res.status = ST_OK;
				return res;
			end
			if (shadow_name[slot] == kept) begin
				res.found  = 1'b1;
				res.slot   = SLOT_IDX_W'(slot);
				res.status = ST_OK;
				return res;
			end
			slot = (slot + 1 >= ENTRIES) ? 0 : slot + 1;
		end
		res.found  = 1'b0;
		res.slot   = '0;
		res.status = ST_OVERFLOW;
		return res;
	endfunction

	// random name of nonzero bytes with the given byte sum
	function automatic logic [SYM_W-1:0] make_name(input int s);
		logic [SYM_W-1:0] nm;
		int lo, hi, n, r, room, add, i;
		nm = '0;
		lo = (s + 254) / 255;
		hi = (s < 8) ? s : 8;
		n  = $urandom_range(hi, lo);
		r  = s - n;
		for (i = 0; i < n; i++) begin
			room = 254 * (n - 1 - i);
			lo   = (r > room) ? r - room : 0;
			hi   = (r < 254) ? r : 254;
			add  = $urandom_range(hi, lo);
			r   -= add;
			nm[8*i +: 8] = 8'(add + 1);
		end
		return nm;
	endfunction

	// random junk past the terminating zero byte
	function automatic logic [SYM_W-1:0] add_tail(input logic [SYM_W-1:0] kept);
		int len;
		len = name_len(kept);
		if (len < 8 && $urandom_range(1, 0))
			return kept | ({$urandom, $urandom} << (8 * (len + 1)));
		return kept;
	endfunction

	function automatic logic [SYM_W-1:0] random_name();
		logic [SYM_W-1:0] nm;
		int len, k;
		nm  = '0;
		len = $urandom_range(8, 1);
		for (k = 0; k < len; k++)
			nm[8*k +: 8] = 8'($urandom_range(255, 1));
		return add_tail(nm);
	endfunction

	task automatic queue_request(input logic op, input logic [SYM_W-1:0] raw);
		symbol_req_t req;
		logic [SYM_W-1:0] kept;
		req.op   = op;
		req.name = raw;
		request_q.push_back(req);
		n_queued++;
		kept = strip_name(raw);
		if (op == OP_INSERT && !known_names.exists(kept)) begin
			known_names[kept] = 1'b1;
			name_pool.push_back(kept);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_accepted != n_queued || probe_results_q.size() != 0);
	endtask

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left   = 0;
	symbol_req_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push        <= 1'b0;
			operation   <= OP_LOOKUP;
			symbol_name <= '0;
			burst_left  = 0;
			gap_left    = 0;
		end else begin
			if (push && !full) begin
				probe_results_q.push_back(probe_symbol(operation, symbol_name));
				n_accepted++;
			end
			if (!push || !full) begin
				if (gap_left != 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (request_q.size() != 0) begin
					next_req = request_q.pop_front();
					push        <= 1'b1;
					operation   <= next_req.op;
					symbol_name <= next_req.name;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(16, 1);
						gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
					end else begin
						burst_left--;
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once traffic is under way
	logic hold_active = 1'b0;
	bit   hold_done   = 1'b0;
	int   hold_cnt    = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
		end else if (hold_active) begin
			hold_cnt++;
			if (hold_cnt >= HOLD_CYCLES) begin
				hold_active <= 1'b0;
				hold_done   = 1'b1;
			end
		end else if (!hold_done && n_accepted >= 100) begin
			hold_active <= 1'b1;
		end
	end

	// receiver and result check
	rx_mode_t      rx_mode = RX_STREAM;
	int            rx_cnt  = 0;
	probe_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (probe_results_q.size() == 0) begin
					$error("unexpected transfer: found %0d slot_index %0d status %0d",
						found, slot_index, status);
					n_errors++;
				end else begin
					want = probe_results_q.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, found);
						n_errors++;
					end
					if (slot_index !== want.slot) begin
						$error("slot_index: expected %0d, got %0d", want.slot, slot_index);
						n_errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						n_errors++;
					end
					if (want.status == ST_OVERFLOW)
						n_overflow++;
					else if (want.found)
						n_found++;
					else
						n_absent++;
				end
			end
			rx_cnt++;
			if (rx_cnt % 200 == 0)
				rx_mode = rx_mode_t'($urandom_range(3, 0));
			if (hold_active)
				pop <= 1'b0;
			else
				case (rx_mode)
					RX_STREAM:  pop <= 1'b1;
					RX_COIN:    pop <= 1'($urandom_range(1, 0));
					RX_SPARSE:  pop <= ($urandom_range(4, 0) == 0);
					default:    pop <= (rx_cnt % 3 != 0);
				endcase
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic op;
		int i, s, pick;

		// directed: extremes, tails after the terminator, wrap past the last entry
		queue_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(OP_INSERT, 64'h0);
		queue_request(OP_LOOKUP, 64'hDEAD_BEEF_0000_0000);
		queue_request(OP_INSERT, 64'h0000_0000_0000_0041);
		queue_request(OP_LOOKUP, 64'h5A5A_5A00_0000_0041);
		// four names homed on the highest home slot: the last wraps around to the bottom
		queue_request(OP_INSERT, 64'h0000_0001_FFFF_FFFF);
		queue_request(OP_INSERT, 64'h0000_00FF_01FF_FFFF);
		queue_request(OP_INSERT, 64'h0000_00FF_FF01_FFFF);
		queue_request(OP_INSERT, 64'h0000_00FF_FFFF_01FF);
		queue_request(OP_LOOKUP, 64'h0000_00FF_FFFF_01FF);
		queue_request(OP_LOOKUP, 64'h0000_00FE_FFFF_FF02);
		queue_request(OP_INSERT, 64'h0000_0002_FFFF_FFFF);
		queue_request(OP_INSERT, 64'h0000_0000_0000_0001);
		queue_request(OP_LOOKUP, 64'h0000_0000_0000_0080);
		queue_request(OP_INSERT, 64'h8080_8080_8080_8080);
		queue_request(OP_INSERT, 64'h0101_0101_0101_0101);
		queue_request(OP_LOOKUP, 64'h7F7F_7F7F_7F7F_7F7F);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// random traffic: new names, hits, collisions on shared home slots, raw noise
		for (i = 0; i < RANDOM_REQS; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 35) begin
				queue_request(OP_INSERT, random_name());
			end else if (pick < 55) begin
				queue_request(OP_LOOKUP, add_tail(name_pool[$urandom_range(name_pool.size() - 1, 0)]));
			end else if (pick < 65) begin
				queue_request(OP_INSERT, add_tail(name_pool[$urandom_range(name_pool.size() - 1, 0)]));
			end else if (pick < 75) begin
				queue_request(OP_LOOKUP, random_name());
			end else if (pick < 90) begin
				s  = byte_sum(name_pool[$urandom_range(name_pool.size() - 1, 0)]);
				op = $urandom_range(3, 0) != 0 ? OP_INSERT : OP_LOOKUP;
				queue_request(op, add_tail(make_name((s == 0) ? 1 : s)));
			end else begin
				queue_request(1'($urandom_range(1, 0)), {$urandom, $urandom});
			end
		end
		wait_drained();
		repeat (ENTRIES + 100) @(negedge clk);

		$display("Checked %0d requests: %0d found, %0d absent, %0d table-full results",
			n_accepted, n_found, n_absent, n_overflow);
		$display("Wrap-around probing, shared home slots and name tails exercised");
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
